>>> design/pcs_pkg.sv
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_LEN     = 4096;
  localparam int OUT_W       = 16;
  localparam int Q_FRAC      = 14;

  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int LEN_W   = $clog2(MAX_LEN);
  localparam int SUM_W   = SAMPLE_BITS + LEN_W;
  localparam int PROD_W  = 2 * SAMPLE_BITS + LEN_W + 1;
  localparam int MUL_W   = 2 * SUM_W;
  localparam int PRD_W   = 2 * MUL_W;
  localparam int MCNT_W  = $clog2(MUL_W);
  localparam int Q_W     = Q_FRAC + 1;
  localparam int BIT_W   = $clog2(Q_FRAC + 1);
  localparam int CMP_W   = PRD_W + 2 * Q_FRAC + 2;
  localparam int ONE_Q14 = 1 << Q_FRAC;

  // wide products needed to close a vector, in issue order
  typedef enum logic [2:0] {
    OP_NXX,
    OP_SXX,
    OP_NYY,
    OP_SYY,
    OP_NXY,
    OP_SXY,
    OP_P,
    OP_R
  } op_t;

  typedef enum logic [1:0] {
    RES_CORR,
    RES_DEGEN,
    RES_OVF
  } res_t;

  typedef struct packed {
    logic acc;
    logic clear;
    logic mul_start;
    logic capture;
    op_t  op;
    logic root_init;
    logic root_step;
    logic out_load;
    res_t kind;
  } pcs_cmd_t;

  typedef struct packed {
    logic ovf_now;
    logic mul_done;
    logic var_zero;
    logic root_last;
    logic out_valid;
  } pcs_sts_t;

endpackage

>>> design/pcs_stream_if.sv
`timescale 1ns / 1ps
interface pcs_in_if;
  import pcs_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;
  logic                          last;

  modport source (output valid, x_sample, y_sample, last, input ready);
  modport sink (input valid, x_sample, y_sample, last, output ready);
endinterface

interface pcs_out_if;
  import pcs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] correlation;
  logic                    degenerate;
  logic                    overflow;

  modport source (output valid, correlation, degenerate, overflow, input ready);
  modport sink (input valid, correlation, degenerate, overflow, output ready);
endinterface

>>> design/pcs_mul.sv
`timescale 1ns / 1ps
module pcs_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pcs_pkg::MUL_W-1:0] a,
  input  logic [pcs_pkg::MUL_W-1:0] b,
  output logic                      done,
  output logic [pcs_pkg::PRD_W-1:0] product
);
  import pcs_pkg::*;

  // shift-add multiplier, one multiplier bit per cycle
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PRD_W-1:0]  a_r, a_nxt;
  logic [MUL_W-1:0]  b_r, b_nxt;
  logic [PRD_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = PRD_W'(a);
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MCNT_W'(MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("multiplier done without a finished run");

endmodule

>>> design/pcs_ctrl.sv
`timescale 1ns / 1ps
module pcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  pcs_pkg::pcs_sts_t sts,
  output logic              in_ready,
  output pcs_pkg::pcs_cmd_t cmd
);
  import pcs_pkg::*;

  typedef enum logic [5:0] {
    ST_ACC    = 6'b000001,
    ST_LAUNCH = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_CHK    = 6'b001000,
    ST_ROOT   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cmd.acc       = 1'b0;
    cmd.clear     = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.capture   = 1'b0;
    cmd.op        = op_r;
    cmd.root_init = 1'b0;
    cmd.root_step = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.kind      = RES_CORR;
    // a closing pair waits until the result register is free
    in_ready = (state_r == ST_ACC) && (!in_last || !sts.out_valid);
    unique case (state_r)
      ST_ACC: begin
        if (in_valid && in_ready) begin
          cmd.acc = 1'b1;
          if (in_last) begin
            if (sts.ovf_now) begin
              cmd.out_load = 1'b1;
              cmd.kind     = RES_OVF;
              cmd.clear    = 1'b1;
            end else begin
              op_nxt    = OP_NXX;
              state_nxt = ST_LAUNCH;
            end
          end
        end
      end
      ST_LAUNCH: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        if (sts.mul_done) begin
          cmd.capture = 1'b1;
          unique case (op_r)
            OP_SYY: state_nxt = ST_CHK;
            OP_R: begin
              cmd.root_init = 1'b1;
              state_nxt     = ST_ROOT;
            end
            OP_NXX: begin op_nxt = OP_SXX; state_nxt = ST_LAUNCH; end
            OP_SXX: begin op_nxt = OP_NYY; state_nxt = ST_LAUNCH; end
            OP_NYY: begin op_nxt = OP_SYY; state_nxt = ST_LAUNCH; end
            OP_NXY: begin op_nxt = OP_SXY; state_nxt = ST_LAUNCH; end
            OP_SXY: begin op_nxt = OP_P;   state_nxt = ST_LAUNCH; end
            OP_P:   begin op_nxt = OP_R;   state_nxt = ST_LAUNCH; end
            default: state_nxt = ST_ACC;
          endcase
        end
      end
      ST_CHK: begin
        if (sts.var_zero) begin
          cmd.out_load = 1'b1;
          cmd.kind     = RES_DEGEN;
          cmd.clear    = 1'b1;
          state_nxt    = ST_ACC;
        end else begin
          op_nxt    = OP_NXY;
          state_nxt = ST_LAUNCH;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.out_load = 1'b1;
        cmd.kind     = RES_CORR;
        cmd.clear    = 1'b1;
        state_nxt    = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      op_r    <= OP_NXX;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

>>> design/pcs_datapath.sv
`timescale 1ns / 1ps
module pcs_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcs_pkg::pcs_cmd_t                    cmd,
  input  logic signed [pcs_pkg::SAMPLE_BITS-1:0] x_sample,
  input  logic signed [pcs_pkg::SAMPLE_BITS-1:0] y_sample,
  input  logic                                 out_ready,
  output pcs_pkg::pcs_sts_t                    sts,
  output logic                                 out_valid,
  output logic signed [pcs_pkg::OUT_W-1:0]     correlation,
  output logic                                 degenerate,
  output logic                                 overflow
);
  import pcs_pkg::*;

  // running sums
  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                     covf_r, covf_nxt;
  logic signed [SUM_W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic        [PROD_W-1:0] sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic signed [PROD_W-1:0] sxy_r, sxy_nxt;

  logic signed [2*SAMPLE_BITS-1:0] pxx, pyy, pxy;

  // closing arithmetic
  logic [MUL_W-1:0] mul_a, mul_b;
  logic             mul_done;
  logic [PRD_W-1:0] prod;
  logic [PRD_W-1:0] t1_r, t1_nxt, p_r, p_nxt, r_r, r_nxt;
  logic [PRD_W-1:0] diff, rdiff;
  logic             ge;
  logic [MUL_W-1:0] vx_r, vx_nxt, vy_r, vy_nxt, cov_r, cov_nxt;
  logic             neg_r, neg_nxt, neg_a, neg_b;
  logic [SUM_W-1:0] sx_mag, sy_mag;
  logic [PROD_W-1:0] sxy_mag;

  // bitwise root search
  logic [CMP_W-1:0] s_r, s_nxt, qp_r, qp_nxt, trial, r_ext, p_ext;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] corr_r, corr_nxt;
  logic                    degen_r, degen_nxt, ovf_r, ovf_nxt;

  assign pxx = x_sample * x_sample;
  assign pyy = y_sample * y_sample;
  assign pxy = x_sample * y_sample;

  always_comb begin
    cnt_nxt  = cnt_r;
    covf_nxt = covf_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sxx_nxt  = sxx_r;
    syy_nxt  = syy_r;
    sxy_nxt  = sxy_r;
    if (cmd.clear) begin
      cnt_nxt  = '0;
      covf_nxt = 1'b0;
      sx_nxt   = '0;
      sy_nxt   = '0;
      sxx_nxt  = '0;
      syy_nxt  = '0;
      sxy_nxt  = '0;
    end else if (cmd.acc) begin
      if (cnt_r < CNT_W'(MAX_LEN)) begin
        sx_nxt  = sx_r + {{(SUM_W-SAMPLE_BITS){x_sample[SAMPLE_BITS-1]}}, x_sample};
        sy_nxt  = sy_r + {{(SUM_W-SAMPLE_BITS){y_sample[SAMPLE_BITS-1]}}, y_sample};
        sxx_nxt = sxx_r + PROD_W'(unsigned'(pxx));
        syy_nxt = syy_r + PROD_W'(unsigned'(pyy));
        sxy_nxt = sxy_r + {{(PROD_W-2*SAMPLE_BITS){pxy[2*SAMPLE_BITS-1]}}, pxy};
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        covf_nxt = 1'b1;
      end
    end
  end

  assign sx_mag  = sx_r[SUM_W-1] ? unsigned'(-sx_r) : unsigned'(sx_r);
  assign sy_mag  = sy_r[SUM_W-1] ? unsigned'(-sy_r) : unsigned'(sy_r);
  assign sxy_mag = sxy_r[PROD_W-1] ? unsigned'(-sxy_r) : unsigned'(sxy_r);

  always_comb begin
    unique case (cmd.op)
      OP_NXX: begin mul_a = MUL_W'(cnt_r);  mul_b = MUL_W'(sxx_r);   end
      OP_SXX: begin mul_a = MUL_W'(sx_mag); mul_b = MUL_W'(sx_mag);  end
      OP_NYY: begin mul_a = MUL_W'(cnt_r);  mul_b = MUL_W'(syy_r);   end
      OP_SYY: begin mul_a = MUL_W'(sy_mag); mul_b = MUL_W'(sy_mag);  end
      OP_NXY: begin mul_a = MUL_W'(cnt_r);  mul_b = MUL_W'(sxy_mag); end
      OP_SXY: begin mul_a = MUL_W'(sx_mag); mul_b = MUL_W'(sy_mag);  end
      OP_P:   begin mul_a = vx_r;           mul_b = vy_r;            end
      OP_R:   begin mul_a = cov_r;          mul_b = cov_r;           end
      default: begin mul_a = '0;            mul_b = '0;              end
    endcase
  end

  pcs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  assign ge    = t1_r >= prod;
  assign diff  = t1_r - prod;
  assign rdiff = prod - t1_r;
  assign neg_a = sxy_r[PROD_W-1];
  assign neg_b = sx_r[SUM_W-1] ^ sy_r[SUM_W-1];

  always_comb begin
    t1_nxt  = t1_r;
    vx_nxt  = vx_r;
    vy_nxt  = vy_r;
    cov_nxt = cov_r;
    neg_nxt = neg_r;
    p_nxt   = p_r;
    r_nxt   = r_r;
    if (cmd.capture) begin
      unique case (cmd.op)
        OP_NXX, OP_NYY, OP_NXY: t1_nxt = prod;
        // variance clamps at zero
        OP_SXX: vx_nxt = ge ? diff[MUL_W-1:0] : '0;
        OP_SYY: vy_nxt = ge ? diff[MUL_W-1:0] : '0;
        OP_SXY: begin
          if (neg_a != neg_b) begin
            cov_nxt = MUL_W'(t1_r + prod);
            neg_nxt = neg_a;
          end else if (ge) begin
            cov_nxt = diff[MUL_W-1:0];
            neg_nxt = neg_a;
          end else begin
            cov_nxt = rdiff[MUL_W-1:0];
            neg_nxt = !neg_a;
          end
        end
        OP_P: p_nxt = prod;
        OP_R: r_nxt = prod;
        default: t1_nxt = t1_r;
      endcase
    end
  end

  // trial (q + 2^b)^2 * P built from q^2*P and q*P
  assign r_ext = CMP_W'({r_r, {(2*Q_FRAC){1'b0}}});
  assign p_ext = CMP_W'(p_r);
  assign trial = s_r + (qp_r << (bit_r + 1'b1)) + (p_ext << (2 * bit_r));

  always_comb begin
    s_nxt   = s_r;
    qp_nxt  = qp_r;
    q_nxt   = q_r;
    bit_nxt = bit_r;
    if (cmd.root_init) begin
      s_nxt   = '0;
      qp_nxt  = '0;
      q_nxt   = '0;
      bit_nxt = BIT_W'(Q_FRAC);
    end else if (cmd.root_step) begin
      if (trial <= r_ext) begin
        s_nxt  = trial;
        qp_nxt = qp_r + (p_ext << bit_r);
        q_nxt  = q_r | (Q_W'(1) << bit_r);
      end
      bit_nxt = bit_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    corr_nxt      = corr_r;
    degen_nxt     = degen_r;
    ovf_nxt       = ovf_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      unique case (cmd.kind)
        RES_CORR: begin
          corr_nxt  = neg_r ? -signed'(OUT_W'(q_r)) : signed'(OUT_W'(q_r));
          degen_nxt = 1'b0;
          ovf_nxt   = 1'b0;
        end
        RES_DEGEN: begin
          corr_nxt  = '0;
          degen_nxt = 1'b1;
          ovf_nxt   = 1'b0;
        end
        RES_OVF: begin
          corr_nxt  = '0;
          degen_nxt = 1'b0;
          ovf_nxt   = 1'b1;
        end
        default: begin
          corr_nxt  = '0;
          degen_nxt = 1'b0;
          ovf_nxt   = 1'b0;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      covf_r      <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      syy_r       <= '0;
      sxy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      covf_r      <= covf_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxx_r       <= sxx_nxt;
      syy_r       <= syy_nxt;
      sxy_r       <= sxy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t1_r   <= t1_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    cov_r  <= cov_nxt;
    neg_r  <= neg_nxt;
    p_r    <= p_nxt;
    r_r    <= r_nxt;
    s_r    <= s_nxt;
    qp_r   <= qp_nxt;
    q_r    <= q_nxt;
    bit_r  <= bit_nxt;
    corr_r <= corr_nxt;
    degen_r <= degen_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign sts.ovf_now   = covf_r || (cnt_r == CNT_W'(MAX_LEN));
  assign sts.mul_done  = mul_done;
  assign sts.var_zero  = (vx_r == '0) || (vy_r == '0);
  assign sts.root_last = (bit_r == '0);
  assign sts.out_valid = out_valid_r;

  assign out_valid   = out_valid_r;
  assign correlation = corr_r;
  assign degenerate  = degen_r;
  assign overflow    = ovf_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("result loaded over a pending result");

  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.kind == RES_CORR) |-> (q_r <= Q_W'(ONE_Q14)))
    else $error("coefficient magnitude above one");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (corr_r == '0 && !degen_r))
    else $error("overflow result carries a coefficient");

endmodule

>>> design/pearson_correlation_stream.sv
`timescale 1ns / 1ps
// Streaming Pearson correlation. Pairs of signed 16-bit samples arrive on
// in_ch, one transfer per cycle while accumulating; the pair with last set
// closes the vector and produces one result on out_ch: the coefficient in
// Q2.14 (16384 is +1.0), truncated toward zero, with degenerate set when
// either variance is zero (a single pair included) and overflow set when
// more than MAX_LEN pairs arrived, both forcing the coefficient to 0. A
// coefficient close runs eight wide products through one shift-add
// multiplier, each launched and captured, then a 15-step bitwise root
// search; a degenerate close stops after the first four products and an
// overflow close loads its result at once. in_ready stays low until the
// result is loaded. A closing pair is held off while a previous result
// has not been taken; other pairs keep flowing.
module pearson_correlation_stream (
  input logic       clk,
  input logic       rst_n,
  pcs_in_if.sink    in_ch,
  pcs_out_if.source out_ch
);
  import pcs_pkg::*;

  pcs_cmd_t cmd;
  pcs_sts_t sts;

  // sequencer: accumulate, then walk the closing products and the root
  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // sums, multiplier, root search and result register
  pcs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .x_sample    (in_ch.x_sample),
    .y_sample    (in_ch.y_sample),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .correlation (out_ch.correlation),
    .degenerate  (out_ch.degenerate),
    .overflow    (out_ch.overflow)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pcs_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] correlation;
    logic                    degenerate;
    logic                    overflow;
  } corr_result_t;

  // running sums of the open vector and the results it has to produce
  class corr_scoreboard;
    longint       n, sx, sy, sxx, syy, sxy;
    bit           too_long;
    corr_result_t expected_q[$];
    int           mismatches, results_seen, degen_seen, ovf_seen;

    function void clear_sums();
      n = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
      too_long = 0;
    endfunction

    // exact q = floor(16384*|cov|/sqrt(vx*vy)), found as the largest q with
    // q^2*vx*vy <= 2^28*cov^2
    function logic [OUT_W-1:0] coeff_mag(longint vx, longint vy, longint cov_mag);
      logic [255:0] p, r, t;
      int lo, hi, mid;
      p = 256'(vx) * 256'(vy);
      r = (256'(cov_mag) * 256'(cov_mag)) << 28;
      lo = 0;
      hi = ONE_Q14;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t = 256'(mid * mid) * p;
        if (t <= r) lo = mid;
        else hi = mid - 1;
      end
      return OUT_W'(lo);
    endfunction

    function void note_pair(logic signed [SAMPLE_BITS-1:0] x,
                            logic signed [SAMPLE_BITS-1:0] y, logic last);
      corr_result_t res;
      longint xi, yi, vx, vy, cov;
      xi = x;
      yi = y;
      if (n < MAX_LEN) begin
        sx += xi; sy += yi;
        sxx += xi * xi; syy += yi * yi; sxy += xi * yi;
        n++;
      end else begin
        too_long = 1;
      end
      if (!last) return;
      res.correlation = '0;
      res.degenerate  = 0;
      res.overflow    = 0;
      if (too_long) begin
        res.overflow = 1;
      end else begin
        vx = n * sxx - sx * sx;
        vy = n * syy - sy * sy;
        if (vx <= 0 || vy <= 0) begin
          res.degenerate = 1;
        end else begin
          cov = n * sxy - sx * sy;
          res.correlation = (cov < 0) ? -coeff_mag(vx, vy, -cov)
                                      : coeff_mag(vx, vy, cov);
        end
      end
      expected_q.push_back(res);
      clear_sums();
    endfunction

    function void check_result(corr_result_t got);
      corr_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: corr %0d degen %0b ovf %0b",
                   got.correlation, got.degenerate, got.overflow);
        return;
      end
      exp_r = expected_q.pop_front();
      degen_seen += exp_r.degenerate;
      ovf_seen   += exp_r.overflow;
      if (got.correlation !== exp_r.correlation || got.degenerate !== exp_r.degenerate
          || got.overflow !== exp_r.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected corr %0d degen %0b ovf %0b, got %0d %0b %0b",
                   results_seen, exp_r.correlation, exp_r.degenerate, exp_r.overflow,
                   got.correlation, got.degenerate, got.overflow);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst_n;
  pcs_in_if  in_ch();
  pcs_out_if out_ch();

  corr_scoreboard sb = new();
  int  cycles;
  int  pairs_sent;
  bit  in_steady;   // sender never idles while set
  corr_result_t got;

  pearson_correlation_stream DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // cycle counter doubles as the watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side backpressure, with a calm window where ready stays high
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (cycles > 30000 && cycles < 90000) || ($urandom_range(99) >= 11);
    end
  end

  // input transfers feed the predictor, result transfers get checked
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_pair(in_ch.x_sample, in_ch.y_sample, in_ch.last);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.correlation = out_ch.correlation;
      got.degenerate  = out_ch.degenerate;
      got.overflow    = out_ch.overflow;
      sb.check_result(got);
    end
  end

  // one pair per call; valid stays high afterwards unless the next call idles
  task automatic send_pair(logic signed [SAMPLE_BITS-1:0] x,
                           logic signed [SAMPLE_BITS-1:0] y, logic last);
    while (!in_steady && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.x_sample <= x;
    in_ch.y_sample <= y;
    in_ch.last     <= last;
    do @(posedge clk); while (!in_ch.ready);
    pairs_sent++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return SAMPLE_BITS'(v);
  endfunction

  // random sample, sometimes full scale, sometimes small
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(3))
      0: return SAMPLE_BITS'($urandom_range(15) - 8);
      1: return SAMPLE_BITS'($urandom_range(511) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // shape: 0 independent, 1 correlated, 2 anti-correlated, 3 one side constant
  task automatic send_vector(int len, int shape);
    logic signed [SAMPLE_BITS-1:0] x, y, k;
    int noise;
    k = rand_sample();
    noise = $urandom_range(3) == 0 ? 0 : $urandom_range(2000);
    for (int i = 0; i < len; i++) begin
      x = rand_sample();
      case (shape)
        1: y = clamp16(int'(x) + int'($urandom_range(2 * noise)) - noise);
        2: y = clamp16(-int'(x) + int'($urandom_range(2 * noise)) - noise);
        3: y = k;
        default: y = rand_sample();
      endcase
      if (shape == 3 && $urandom_range(1)) send_pair(y, x, i == len - 1);
      else send_pair(x, y, i == len - 1);
    end
  endtask

  initial begin
    int len;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.x_sample = '0;
    in_ch.y_sample = '0;
    in_ch.last     = 1'b0;
    in_steady      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single pair, extremes, perfect +1 and -1, zero covariance, constant side
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(16'sd5, 16'sd7, 1'b0);
    send_pair(16'sd5, -16'sd7, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(-16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(-16'sd1, 16'sd0, 1'b1);
    send_pair(16'sd3, 16'sd9, 1'b0);
    send_pair(16'sd1, 16'sd2, 1'b0);
    send_pair(-16'sd2, -16'sd8, 1'b1);
    send_pair(-16'sd32768, 16'sd12, 1'b0);
    send_pair(16'sd32767, 16'sd11, 1'b1);

    // sender holds off until the block has drained
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);

    while (pairs_sent < 2000) begin
      in_steady = (pairs_sent > 700 && pairs_sent < 1000);
      case ($urandom_range(19))
        0, 1: len = $urandom_range(200, 17);
        default: len = $urandom_range(16, 1);
      endcase
      send_vector(len, $urandom_range(3));
    end
    in_steady = 1'b0;
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (600) @(posedge clk);

    $display("%0d pairs sent, %0d results checked (%0d degenerate, %0d overflow)",
             pairs_sent, sb.results_seen, sb.degen_seen, sb.ovf_seen);
    $display("vector lengths 1..200 with independent, correlated and constant data");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
